/* rtl/fsf_pkg.sv */
package fsf_pkg;

   // word format
   localparam int WORD_W  = 32;
   localparam int FRAC_W  = 24;

   // radius path
   localparam int SUMSQ_W = 2 * WORD_W;
   localparam int R_W     = SUMSQ_W / 2;
   localparam int T_W     = R_W + 1;

   // root of the fold term, radicand t << FRAC_W rounded up to an even width
   localparam int Q_RAD_W = ((T_W + FRAC_W + 1) / 2) * 2;
   localparam int Q_W     = Q_RAD_W / 2;

   // scaled weight and products
   localparam int V_W     = WORD_W - 1;
   localparam int VQ_W    = V_W + Q_W;
   localparam int VMY_W   = V_W + WORD_W;
   localparam int RQ_W    = R_W + Q_W;
   localparam int NUMY_W  = VMY_W + FRAC_W;
   localparam int TXS_W   = VQ_W - FRAC_W;

   // quotient bits kept; anything at or above 2**QUO_W saturates the sum
   localparam int QUO_W   = WORD_W + 2;
   localparam int SUM_W   = QUO_W + 2;

   localparam int OUTQ_DEPTH = 128;

   localparam logic [WORD_W-1:0] SQRT_HALF = 32'hB504_F334;
   localparam logic [V_W-1:0]    V_RESET   = 31'h00B5_04F3;
   localparam logic [R_W-1:0]    ONE_Q     = 32'h0100_0000;
   localparam logic [WORD_W-1:0] WORD_MAX  = 32'h7FFF_FFFF;
   localparam logic [WORD_W-1:0] WORD_MIN  = 32'h8000_0000;

   typedef struct packed {
      logic signed [WORD_W-1:0] new_x;
      logic signed [WORD_W-1:0] new_y;
      logic                     degenerate;
   } result_type;

endpackage

/* rtl/flame_sqrt_fold_transform_unit.sv */
// channel  | handshake           | words
// ---------+---------------------+-------------------------------------------------
// req      | req_valid/req_ready | req_point_x, req_point_y, req_acc_x, req_acc_y, req_coin
// rsp      | rsp_valid/rsp_ready | rsp_new_x, rsp_new_y, rsp_degenerate
// csr      | csr_wen             | csr_wdata (weight, Q8.24)
//
// one word accepted per cycle while req_ready is high
// the pipe runs through the 32-stage radius root, the 29-stage fold root and the 35-stage dividers
// reset clears all valid bits and queue counters and sets weight to 1.0
// the pipe never stalls: results land in a 128-word queue and req_ready drops
// only while 128 words are outstanding
module flame_sqrt_fold_transform_unit
   import fsf_pkg::*;
#(
   parameter int OUT_DEPTH = OUTQ_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [WORD_W-1:0] req_point_x,
   input  logic signed [WORD_W-1:0] req_point_y,
   input  logic signed [WORD_W-1:0] req_acc_x,
   input  logic signed [WORD_W-1:0] req_acc_y,
   input  logic                     req_coin,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [WORD_W-1:0] rsp_new_x,
   output logic signed [WORD_W-1:0] rsp_new_y,
   output logic                     rsp_degenerate,
   input  logic                     csr_wen,
   input  logic [WORD_W-1:0]        csr_wdata
);

   typedef struct packed {
      logic [WORD_W-1:0]        mx;
      logic                     sx;
      logic [WORD_W-1:0]        my;
      logic                     sy;
      logic signed [WORD_W-1:0] ax;
      logic signed [WORD_W-1:0] ay;
      logic                     coin;
   } rside_type;

   typedef struct packed {
      logic [R_W-1:0]           r;
      logic [WORD_W-1:0]        my;
      logic                     sy;
      logic signed [WORD_W-1:0] ax;
      logic signed [WORD_W-1:0] ay;
      logic                     coin;
   } qside_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] ax;
      logic signed [WORD_W-1:0] ay;
      logic                     coin;
      logic                     deg;
      logic                     ny;
      logic [TXS_W-1:0]         txs;
   } dside_type;

   function automatic logic [WORD_W-1:0] add_sat(
      input logic [WORD_W-1:0] acc,
      input logic              neg,
      input logic              big,
      input logic [QUO_W-1:0]  mag
   );
      logic [SUM_W-1:0] s;
      logic [WORD_W-1:0] res;
      s = neg ? {{(SUM_W-WORD_W){acc[WORD_W-1]}}, acc} - SUM_W'(mag)
              : {{(SUM_W-WORD_W){acc[WORD_W-1]}}, acc} + SUM_W'(mag);
      if (big) begin
         res = neg ? WORD_MIN : WORD_MAX;
      end else if (s[SUM_W-1:WORD_W-1] == '0 || s[SUM_W-1:WORD_W-1] == '1) begin
         res = s[WORD_W-1:0];
      end else begin
         res = s[SUM_W-1] ? WORD_MIN : WORD_MAX;
      end
      return res;
   endfunction

   // scaled weight v = |weight| * sqrt(2)/2, rounded
   logic [V_W-1:0]    v_ff;
   logic              vneg_ff;
   logic [WORD_W-1:0] wmag;
   logic [SUMSQ_W-1:0] wprod;

   assign wmag  = csr_wdata[WORD_W-1] ? (~csr_wdata + 1'b1) : csr_wdata;
   assign wprod = SUMSQ_W'(wmag) * SUMSQ_W'(SQRT_HALF) + SUMSQ_W'(64'h8000_0000);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff    <= V_RESET;
         vneg_ff <= 1'b0;
      end else if (csr_wen) begin
         v_ff    <= wprod[WORD_W +: V_W];
         vneg_ff <= csr_wdata[WORD_W-1];
      end
   end

   logic req_fire;
   assign req_fire = req_valid & req_ready;

   // stage 1: capture
   logic                     s1_vld_ff;
   logic signed [WORD_W-1:0] s1_x_ff, s1_y_ff, s1_ax_ff, s1_ay_ff;
   logic                     s1_coin_ff;

   // stage 2: magnitudes
   logic                     s2_vld_ff;
   logic [WORD_W-1:0]        s2_mx_ff, s2_my_ff;
   logic                     s2_sx_ff, s2_sy_ff;
   logic signed [WORD_W-1:0] s2_ax_ff, s2_ay_ff;
   logic                     s2_coin_ff;

   // stage 3: squares
   logic                     s3_vld_ff;
   logic [SUMSQ_W-1:0]       s3_sqx_ff, s3_sqy_ff;
   rside_type                s3_side_ff;

   // stage 4: sum of squares
   logic                     s4_vld_ff;
   logic [SUMSQ_W-1:0]       s4_sum_ff;
   rside_type                s4_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= req_fire;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
      if (req_fire) begin
         s1_x_ff    <= req_point_x;
         s1_y_ff    <= req_point_y;
         s1_ax_ff   <= req_acc_x;
         s1_ay_ff   <= req_acc_y;
         s1_coin_ff <= req_coin;
      end
      s2_mx_ff   <= s1_x_ff[WORD_W-1] ? (~s1_x_ff + 1'b1) : s1_x_ff;
      s2_my_ff   <= s1_y_ff[WORD_W-1] ? (~s1_y_ff + 1'b1) : s1_y_ff;
      s2_sx_ff   <= s1_x_ff[WORD_W-1];
      s2_sy_ff   <= s1_y_ff[WORD_W-1];
      s2_ax_ff   <= s1_ax_ff;
      s2_ay_ff   <= s1_ay_ff;
      s2_coin_ff <= s1_coin_ff;

      s3_sqx_ff       <= SUMSQ_W'(s2_mx_ff) * SUMSQ_W'(s2_mx_ff);
      s3_sqy_ff       <= SUMSQ_W'(s2_my_ff) * SUMSQ_W'(s2_my_ff);
      s3_side_ff.mx   <= s2_mx_ff;
      s3_side_ff.sx   <= s2_sx_ff;
      s3_side_ff.my   <= s2_my_ff;
      s3_side_ff.sy   <= s2_sy_ff;
      s3_side_ff.ax   <= s2_ax_ff;
      s3_side_ff.ay   <= s2_ay_ff;
      s3_side_ff.coin <= s2_coin_ff;

      s4_sum_ff  <= s3_sqx_ff + s3_sqy_ff;
      s4_side_ff <= s3_side_ff;
   end

   // r = floor(sqrt(x^2 + y^2))
   logic            rt_vld;
   logic [R_W-1:0]  rt_root;
   rside_type       rt_side;

   fsf_sqrt #(
      .RAD_W  (SUMSQ_W),
      .SIDE_W ($bits(rside_type))
   ) u_sqrt_r (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s4_vld_ff),
      .in_rad    (s4_sum_ff),
      .in_side   (s4_side_ff),
      .out_valid (rt_vld),
      .out_root  (rt_root),
      .out_side  (rt_side)
   );

   // stage 5: t = r + x, never negative
   logic           s5_vld_ff;
   logic [T_W-1:0] s5_t_ff;
   qside_type      s5_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else begin
         s5_vld_ff <= rt_vld;
      end
      s5_t_ff         <= rt_side.sx ? T_W'(rt_root) - T_W'(rt_side.mx)
                                    : T_W'(rt_root) + T_W'(rt_side.mx);
      s5_side_ff.r    <= rt_root;
      s5_side_ff.my   <= rt_side.my;
      s5_side_ff.sy   <= rt_side.sy;
      s5_side_ff.ax   <= rt_side.ax;
      s5_side_ff.ay   <= rt_side.ay;
      s5_side_ff.coin <= rt_side.coin;
   end

   // q = floor(sqrt(t << FRAC_W))
   logic             qt_vld;
   logic [Q_W-1:0]   qt_root;
   qside_type        qt_side;
   logic [Q_RAD_W-1:0] q_rad;

   assign q_rad = Q_RAD_W'({s5_t_ff, {FRAC_W{1'b0}}});

   fsf_sqrt #(
      .RAD_W  (Q_RAD_W),
      .SIDE_W ($bits(qside_type))
   ) u_sqrt_q (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s5_vld_ff),
      .in_rad    (q_rad),
      .in_side   (s5_side_ff),
      .out_valid (qt_vld),
      .out_root  (qt_root),
      .out_side  (qt_side)
   );

   // stage 6: products and signs
   logic                     s6_vld_ff;
   logic [VQ_W-1:0]          s6_vq_ff;
   logic [VMY_W-1:0]         s6_vmy_ff;
   logic [RQ_W-1:0]          s6_rq_ff;
   logic [Q_W-1:0]           s6_q_ff;
   logic [R_W-1:0]           s6_r_ff;
   logic                     s6_deg_ff, s6_nx_ff, s6_ny_ff, s6_coin_ff;
   logic signed [WORD_W-1:0] s6_ax_ff, s6_ay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_vld_ff <= 1'b0;
      end else begin
         s6_vld_ff <= qt_vld;
      end
      s6_vq_ff   <= VQ_W'(v_ff) * VQ_W'(qt_root);
      s6_vmy_ff  <= VMY_W'(v_ff) * VMY_W'(qt_side.my);
      s6_rq_ff   <= RQ_W'(qt_side.r) * RQ_W'(qt_root);
      s6_q_ff    <= qt_root;
      s6_r_ff    <= qt_side.r;
      // r == 0 forces t == 0 and so q == 0
      s6_deg_ff  <= qt_root == '0;
      s6_nx_ff   <= vneg_ff != (qt_side.r < ONE_Q);
      s6_ny_ff   <= qt_side.coin ? (vneg_ff == qt_side.sy) : (vneg_ff != qt_side.sy);
      s6_coin_ff <= qt_side.coin;
      s6_ax_ff   <= qt_side.ax;
      s6_ay_ff   <= qt_side.ay;
   end

   // dividers: x term v*q / r, y term v*|y| / q or (v*|y| << FRAC_W) / (r*q)
   logic [NUMY_W-1:0] ny_num;
   logic [RQ_W-1:0]   ny_den;
   dside_type         dy_side_in;

   assign ny_num = s6_coin_ff ? NUMY_W'(s6_vmy_ff) : {s6_vmy_ff, {FRAC_W{1'b0}}};
   assign ny_den = s6_coin_ff ? RQ_W'(s6_q_ff) : s6_rq_ff;

   assign dy_side_in.ax   = s6_ax_ff;
   assign dy_side_in.ay   = s6_ay_ff;
   assign dy_side_in.coin = s6_coin_ff;
   assign dy_side_in.deg  = s6_deg_ff;
   assign dy_side_in.ny   = s6_ny_ff;
   assign dy_side_in.txs  = s6_vq_ff[VQ_W-1:FRAC_W];

   logic             dx_vld, dx_ovf, dx_nx;
   logic [QUO_W-1:0] dx_quo;
   logic             dy_vld, dy_ovf;
   logic [QUO_W-1:0] dy_quo;
   dside_type        dy_side;

   fsf_div #(
      .NUM_W  (VQ_W),
      .DEN_W  (R_W),
      .QW     (QUO_W),
      .SIDE_W (1)
   ) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s6_vld_ff),
      .in_num    (s6_vq_ff),
      .in_den    (s6_r_ff),
      .in_side   (s6_nx_ff),
      .out_valid (dx_vld),
      .out_quo   (dx_quo),
      .out_ovf   (dx_ovf),
      .out_side  (dx_nx)
   );

   fsf_div #(
      .NUM_W  (NUMY_W),
      .DEN_W  (RQ_W),
      .QW     (QUO_W),
      .SIDE_W ($bits(dside_type))
   ) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s6_vld_ff),
      .in_num    (ny_num),
      .in_den    (ny_den),
      .in_side   (dy_side_in),
      .out_valid (dy_vld),
      .out_quo   (dy_quo),
      .out_ovf   (dy_ovf),
      .out_side  (dy_side)
   );

   // stage 8: accumulate with saturation
   logic             tx_big;
   logic [QUO_W-1:0] tx_mag;
   logic             s8_vld_ff;
   result_type       s8_res_ff;

   assign tx_big = dy_side.coin ? (dy_side.txs[TXS_W-1:QUO_W] != '0) : dx_ovf;
   assign tx_mag = dy_side.coin ? dy_side.txs[QUO_W-1:0] : dx_quo;

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_vld_ff <= 1'b0;
      end else begin
         s8_vld_ff <= dx_vld & dy_vld;
      end
      s8_res_ff.degenerate <= dy_side.deg;
      if (dy_side.deg) begin
         s8_res_ff.new_x <= dy_side.ax;
         s8_res_ff.new_y <= dy_side.ay;
      end else begin
         s8_res_ff.new_x <= add_sat(dy_side.ax, dx_nx, tx_big, tx_mag);
         s8_res_ff.new_y <= add_sat(dy_side.ay, dy_side.ny, dy_ovf, dy_quo);
      end
   end

   result_type rsp_word;

   fsf_outq #(
      .DEPTH (OUT_DEPTH)
   ) u_outq (
      .clock     (clock),
      .reset     (reset),
      .take      (req_fire),
      .wr_valid  (s8_vld_ff),
      .wr_data   (s8_res_ff),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_word),
      .room      (req_ready)
   );

   assign rsp_new_x      = rsp_word.new_x;
   assign rsp_new_y      = rsp_word.new_y;
   assign rsp_degenerate = rsp_word.degenerate;

endmodule

/* rtl/fsf_sqrt.sv */
module fsf_sqrt
   import fsf_pkg::*;
#(
   parameter int RAD_W  = SUMSQ_W,
   parameter int SIDE_W = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [RAD_W-1:0]      in_rad,
   input  logic [SIDE_W-1:0]     in_side,
   output logic                  out_valid,
   output logic [RAD_W/2-1:0]    out_root,
   output logic [SIDE_W-1:0]     out_side
);

   localparam int K     = RAD_W / 2;
   localparam int REM_W = K + 2;

   logic              vld_ff  [K];
   logic [RAD_W-1:0]  rad_ff  [K];
   logic [REM_W-1:0]  rem_ff  [K];
   logic [K-1:0]      root_ff [K];
   logic [SIDE_W-1:0] side_ff [K];

   // one result bit per stage, two radicand bits consumed per stage
   for (genvar s = 0; s < K; s++) begin : g_stage
      logic              p_vld;
      logic [RAD_W-1:0]  p_rad;
      logic [REM_W-1:0]  p_rem;
      logic [K-1:0]      p_root;
      logic [SIDE_W-1:0] p_side;
      logic [REM_W-1:0]  rem_shl;
      logic [REM_W-1:0]  trial;
      logic              fits;

      if (s == 0) begin : g_first
         assign p_vld  = in_valid;
         assign p_rad  = in_rad;
         assign p_rem  = '0;
         assign p_root = '0;
         assign p_side = in_side;
      end else begin : g_next
         assign p_vld  = vld_ff[s-1];
         assign p_rad  = rad_ff[s-1];
         assign p_rem  = rem_ff[s-1];
         assign p_root = root_ff[s-1];
         assign p_side = side_ff[s-1];
      end

      assign rem_shl = {p_rem[REM_W-3:0], p_rad[RAD_W-1 -: 2]};
      assign trial   = {p_root, 2'b01};
      assign fits    = rem_shl >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= p_vld;
         end
         rad_ff[s]  <= p_rad << 2;
         rem_ff[s]  <= fits ? rem_shl - trial : rem_shl;
         root_ff[s] <= {p_root[K-2:0], fits};
         side_ff[s] <= p_side;
      end
   end

   assign out_valid = vld_ff[K-1];
   assign out_root  = root_ff[K-1];
   assign out_side  = side_ff[K-1];

endmodule

/* rtl/fsf_div.sv */
module fsf_div
   import fsf_pkg::*;
#(
   parameter int NUM_W  = VQ_W,
   parameter int DEN_W  = R_W,
   parameter int QW     = QUO_W,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [QW-1:0]     out_quo,
   output logic              out_ovf,
   output logic [SIDE_W-1:0] out_side
);

   localparam int HI_W  = NUM_W - QW;
   localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;
   localparam int REM_W = DEN_W + 1;

   logic [HI_W-1:0]   num_hi;
   logic              ovf;

   logic              pre_vld_ff;
   logic [DEN_W-1:0]  pre_rem_ff;
   logic [QW-1:0]     pre_lo_ff;
   logic [DEN_W-1:0]  pre_den_ff;
   logic              pre_ovf_ff;
   logic [SIDE_W-1:0] pre_side_ff;

   logic              vld_ff  [QW];
   logic [DEN_W-1:0]  rem_ff  [QW];
   logic [QW-1:0]     lo_ff   [QW];
   logic [DEN_W-1:0]  den_ff  [QW];
   logic [QW-1:0]     quo_ff  [QW];
   logic              ovf_ff  [QW];
   logic [SIDE_W-1:0] side_ff [QW];

   // quotient does not fit in QW bits when the upper part alone reaches the divisor
   assign num_hi = in_num[NUM_W-1:QW];
   assign ovf    = CMP_W'(num_hi) >= CMP_W'(in_den);

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_vld_ff <= 1'b0;
      end else begin
         pre_vld_ff <= in_valid;
      end
      pre_rem_ff  <= DEN_W'(num_hi);
      pre_lo_ff   <= in_num[QW-1:0];
      pre_den_ff  <= in_den;
      pre_ovf_ff  <= ovf;
      pre_side_ff <= in_side;
   end

   for (genvar s = 0; s < QW; s++) begin : g_stage
      logic              p_vld;
      logic [DEN_W-1:0]  p_rem;
      logic [QW-1:0]     p_lo;
      logic [DEN_W-1:0]  p_den;
      logic [QW-1:0]     p_quo;
      logic              p_ovf;
      logic [SIDE_W-1:0] p_side;
      logic [REM_W-1:0]  rs;
      logic [REM_W-1:0]  diff;
      logic              fits;

      if (s == 0) begin : g_first
         assign p_vld  = pre_vld_ff;
         assign p_rem  = pre_rem_ff;
         assign p_lo   = pre_lo_ff;
         assign p_den  = pre_den_ff;
         assign p_quo  = '0;
         assign p_ovf  = pre_ovf_ff;
         assign p_side = pre_side_ff;
      end else begin : g_next
         assign p_vld  = vld_ff[s-1];
         assign p_rem  = rem_ff[s-1];
         assign p_lo   = lo_ff[s-1];
         assign p_den  = den_ff[s-1];
         assign p_quo  = quo_ff[s-1];
         assign p_ovf  = ovf_ff[s-1];
         assign p_side = side_ff[s-1];
      end

      assign rs   = {p_rem, p_lo[QW-1]};
      assign diff = rs - {1'b0, p_den};
      assign fits = rs >= {1'b0, p_den};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= p_vld;
         end
         rem_ff[s]  <= fits ? diff[DEN_W-1:0] : rs[DEN_W-1:0];
         lo_ff[s]   <= p_lo << 1;
         den_ff[s]  <= p_den;
         quo_ff[s]  <= {p_quo[QW-2:0], fits};
         ovf_ff[s]  <= p_ovf;
         side_ff[s] <= p_side;
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign out_quo   = quo_ff[QW-1];
   assign out_ovf   = ovf_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule

/* rtl/fsf_outq.sv */
module fsf_outq
   import fsf_pkg::*;
#(
   parameter int DEPTH = OUTQ_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic       wr_valid,
   input  result_type wr_data,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data,
   output logic       room
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   result_type    mem [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] inflight_ff, inflight_in;
   logic          out_vld_ff, out_vld_in;
   result_type    out_data_ff;
   logic          load;
   logic          pop;

   assign pop  = out_vld_ff & out_ready;
   // output register doubles as the registered read port
   assign load = (cnt_ff != '0) & (~out_vld_ff | out_ready);

   always_comb begin
      wr_ptr_in   = wr_ptr_ff;
      rd_ptr_in   = rd_ptr_ff;
      if (wr_valid) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (load) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      cnt_in      = cnt_ff + CW'(wr_valid) - CW'(load);
      inflight_in = inflight_ff + CW'(take) - CW'(pop);
      out_vld_in  = load | (out_vld_ff & ~out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         cnt_ff      <= '0;
         inflight_ff <= '0;
         out_vld_ff  <= 1'b0;
      end else begin
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         cnt_ff      <= cnt_in;
         inflight_ff <= inflight_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_valid) begin
         mem[wr_ptr_ff] <= wr_data;
      end
      if (load) begin
         out_data_ff <= mem[rd_ptr_ff];
      end
   end

   // every accepted word has a slot reserved, so the pipe never stalls
   assign room      = inflight_ff < CW'(DEPTH);
   assign out_valid = out_vld_ff;
   assign out_data  = out_data_ff;

endmodule

/* rtl/fsf_checker.sv */
module fsf_checker
   import fsf_pkg::*;
#(
   parameter int DEPTH = OUTQ_DEPTH
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [WORD_W-1:0] rsp_new_x,
   input logic [WORD_W-1:0] rsp_new_y,
   input logic              rsp_degenerate
);

   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0] cnt_ff, cnt_in;

   // words accepted but not yet delivered
   assign cnt_in = cnt_ff + CW'(req_valid & req_ready) - CW'(rsp_valid & rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before the word was taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_new_x) && $stable(rsp_new_y) && $stable(rsp_degenerate))
      else $error("rsp word changed while stalled");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> cnt_ff != '0)
      else $error("result shown with no word outstanding");

   a_credit: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> cnt_ff == CW'(DEPTH))
      else $error("req_ready low while queue space remains");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

endmodule

bind flame_sqrt_fold_transform_unit fsf_checker #(.DEPTH(OUT_DEPTH)) u_fsf_checker (.*);
